// ===== src/assert_macros.svh =====
// Assertion macros used by the top RTL file of the reorder receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is disabled while reset is asserted.
`define SRRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds during reset.
`define SRRR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/srrr_pkg.sv =====
// Shared constants and types of the selective repeat reorder receiver.
package srrr_pkg;

	// Reorder window depth; slot index is seq modulo the depth (power of two).
	localparam int WINDOW_SLOTS = 16;
	localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);
	localparam int RUN_BITS     = $clog2(WINDOW_SLOTS + 1);
	localparam int HANDLE_BITS  = 16;

	localparam int SEQ_W    = 32;
	localparam int LEN_W    = 11;
	localparam int HANDLE_W = 16;

	// Result kinds
	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	typedef struct packed {
		logic [SEQ_W-1:0]       seq;
		logic                   fin;
		logic [LEN_W-1:0]       len;
		logic [HANDLE_BITS-1:0] handle;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== src/srrr_slot_ram.sv =====
// Simple dual-port slot memory with registered read.
module srrr_slot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/srrr_run_scan.sv =====
// Finds the run of buffered successors starting at the expected slot.
module srrr_run_scan import srrr_pkg::*; (
	input  logic [WINDOW_SLOTS-1:0] valid,
	input  logic [WINDOW_SLOTS-1:0] fin,
	input  logic [SLOT_BITS-1:0]    base,
	output logic [RUN_BITS-1:0]     run,
	output logic                    last_fin
);

	logic [2*WINDOW_SLOTS-1:0] dbl_v;
	logic [2*WINDOW_SLOTS-1:0] dbl_f;
	logic [WINDOW_SLOTS-1:0]   rot_v;
	logic [WINDOW_SLOTS-1:0]   rot_f;
	logic [RUN_BITS-1:0]       run_m1;

	// rotate so that bit 0 is the slot of the expected sequence number
	assign dbl_v = {valid, valid} >> base;
	assign dbl_f = {fin, fin} >> base;
	assign rot_v = dbl_v[WINDOW_SLOTS-1:0];
	assign rot_f = dbl_f[WINDOW_SLOTS-1:0];

	// count of trailing ones
	always_comb begin
		run = RUN_BITS'(WINDOW_SLOTS);
		for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
			if (!rot_v[i]) begin
				run = RUN_BITS'(i);
			end
		end
	end

	assign run_m1   = run - RUN_BITS'(1);
	assign last_fin = (run == '0) ? 1'b0 : rot_f[run_m1[SLOT_BITS-1:0]];

endmodule

// ===== src/selective_repeat_reorder_receiver_top.sv =====
// Selective repeat receiver: takes one packet header per transaction and
// emits acks and in-order deliveries. A header that only causes an ack, or
// none, passes through accept and decide. An in-order header without fin
// passes through accept, deliver and ack, then reads and delivers each
// buffered successor drained from the slot memory, and gives a final ack when
// a drained successor carries fin; an in-order header with fin passes through
// accept, deliver and final ack. The registered read of the slot memory paces
// the drain. A stall on the result side holds each step that emits a result.
// A waiting result sits in the output register, so a new header is taken
// while it is outstanding. Reset needs no clearing pass; slot valid bits are
// flip-flops cleared at once.
module selective_repeat_reorder_receiver_top import srrr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_stall,
	input  logic                malformed,
	input  logic [SEQ_W-1:0]    seq_number,
	input  logic                fin_flag,
	input  logic [LEN_W-1:0]    payload_len,
	input  logic [HANDLE_W-1:0] payload_handle,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                kind,
	output logic [SEQ_W-1:0]    ack_number,
	output logic                ack_fin,
	output logic [SEQ_W-1:0]    deliver_seq,
	output logic [LEN_W-1:0]    deliver_len,
	output logic [HANDLE_W-1:0] deliver_handle,
	output logic                last_of_run
);

`include "assert_macros.svh"

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RUNACK = 3'd2;
	localparam logic [2:0] S_DRD    = 3'd3;
	localparam logic [2:0] S_DWR    = 3'd4;
	localparam logic [2:0] S_FINACK = 3'd5;

	logic [2:0]              state_q, state_d;
	logic [SEQ_W-1:0]        expected_q, expected_d;
	logic                    done_q, done_d;
	logic [WINDOW_SLOTS-1:0] slot_valid_q, slot_valid_d;
	logic [WINDOW_SLOTS-1:0] slot_fin_q, slot_fin_d;
	logic [RUN_BITS-1:0]     run_q, run_d;
	logic                    fin_seen_q, fin_seen_d;

	// latched header
	logic                   mal_q;
	logic [SEQ_W-1:0]       seq_q;
	logic                   fin_q;
	logic [LEN_W-1:0]       len_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// output register
	logic                res_valid_q;
	logic                kind_q;
	logic [SEQ_W-1:0]    ack_number_q;
	logic                ack_fin_q;
	logic [SEQ_W-1:0]    deliver_seq_q;
	logic [LEN_W-1:0]    deliver_len_q;
	logic [HANDLE_W-1:0] deliver_handle_q;
	logic                last_q;

	logic                emit;
	logic                e_kind;
	logic [SEQ_W-1:0]    e_ack_number;
	logic                e_ack_fin;
	logic [SEQ_W-1:0]    e_deliver_seq;
	logic [LEN_W-1:0]    e_deliver_len;
	logic [HANDLE_W-1:0] e_deliver_handle;
	logic                e_last;

	logic                out_free;
	logic                pkt_acc;
	logic [SEQ_W-1:0]    seq_delta;
	logic [SLOT_BITS-1:0] seq_idx;
	logic [SLOT_BITS-1:0] exp_idx;

	logic                ram_we;
	logic                ram_re;
	slot_entry_t         ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;
	slot_entry_t         rd_entry;

	logic [RUN_BITS-1:0] scan_run;
	logic                scan_last_fin;
	logic                fs_now;

	logic                in_drain;
	logic                exp_step_ok;

	assign pkt_stall = (state_q != S_IDLE);
	assign pkt_acc   = pkt_valid && !pkt_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign seq_delta = seq_q - expected_q;
	assign seq_idx   = seq_q[SLOT_BITS-1:0];
	assign exp_idx   = expected_q[SLOT_BITS-1:0];
	assign rd_entry  = slot_entry_t'(ram_rdata);
	assign fs_now    = fin_seen_q | rd_entry.fin;

	assign in_drain    = (state_q == S_DRD) || (state_q == S_DWR);
	assign exp_step_ok = (state_q == S_DECIDE) || (state_q == S_DWR);

	assign ram_wdata.seq    = seq_q;
	assign ram_wdata.fin    = fin_q;
	assign ram_wdata.len    = len_q;
	assign ram_wdata.handle = handle_q;

	srrr_slot_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (seq_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (exp_idx),
		.rdata (ram_rdata)
	);

	srrr_run_scan u_scan (
		.valid    (slot_valid_q),
		.fin      (slot_fin_q),
		.base     (exp_idx),
		.run      (scan_run),
		.last_fin (scan_last_fin)
	);

	always_comb begin
		state_d          = state_q;
		expected_d       = expected_q;
		done_d           = done_q;
		slot_valid_d     = slot_valid_q;
		slot_fin_d       = slot_fin_q;
		run_d            = run_q;
		fin_seen_d       = fin_seen_q;
		ram_we           = 1'b0;
		ram_re           = 1'b0;
		emit             = 1'b0;
		e_kind           = KIND_ACK;
		e_ack_number     = '0;
		e_ack_fin        = 1'b0;
		e_deliver_seq    = '0;
		e_deliver_len    = '0;
		e_deliver_handle = '0;
		e_last           = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (pkt_acc) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (done_q || (mal_q && expected_q == '0)) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					if (!mal_q && seq_delta == '0) begin
						e_kind           = KIND_DELIVER;
						e_deliver_seq    = seq_q;
						e_deliver_len    = len_q;
						e_deliver_handle = HANDLE_W'(handle_q);
						expected_d       = seq_q + SEQ_W'(1);
						state_d          = fin_q ? S_FINACK : S_RUNACK;
					end else begin
						// ack only; an early packet within the window is also buffered
						e_ack_number = expected_q;
						e_ack_fin    = fin_q;
						e_last       = 1'b1;
						state_d      = S_IDLE;
						if (!mal_q && seq_delta < SEQ_W'(WINDOW_SLOTS)) begin
							ram_we                = 1'b1;
							slot_valid_d[seq_idx] = 1'b1;
							slot_fin_d[seq_idx]   = fin_q;
						end
					end
				end
			end
			S_RUNACK: begin
				if (out_free) begin
					emit         = 1'b1;
					e_ack_number = expected_q + SEQ_W'(scan_run);
					e_ack_fin    = scan_last_fin;
					e_last       = (scan_run == '0);
					run_d        = scan_run;
					fin_seen_d   = 1'b0;
					state_d      = (scan_run == '0) ? S_IDLE : S_DRD;
				end
			end
			S_DRD: begin
				ram_re  = 1'b1;
				state_d = S_DWR;
			end
			S_DWR: begin
				if (out_free) begin
					emit                  = 1'b1;
					e_kind                = KIND_DELIVER;
					e_deliver_seq         = rd_entry.seq;
					e_deliver_len         = rd_entry.len;
					e_deliver_handle      = HANDLE_W'(rd_entry.handle);
					e_last                = (run_q == RUN_BITS'(1)) && !fs_now;
					slot_valid_d[exp_idx] = 1'b0;
					expected_d            = expected_q + SEQ_W'(1);
					run_d                 = run_q - RUN_BITS'(1);
					fin_seen_d            = fs_now;
					if (run_q == RUN_BITS'(1)) begin
						state_d = fs_now ? S_FINACK : S_IDLE;
					end else begin
						state_d = S_DRD;
					end
				end
			end
			S_FINACK: begin
				if (out_free) begin
					emit         = 1'b1;
					e_ack_number = expected_q;
					e_ack_fin    = 1'b1;
					e_last       = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			expected_q   <= '0;
			done_q       <= 1'b0;
			slot_valid_q <= '0;
			slot_fin_q   <= '0;
			run_q        <= '0;
			fin_seen_q   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			expected_q   <= expected_d;
			done_q       <= done_d;
			slot_valid_q <= slot_valid_d;
			slot_fin_q   <= slot_fin_d;
			run_q        <= run_d;
			fin_seen_q   <= fin_seen_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			mal_q    <= malformed;
			seq_q    <= seq_number;
			fin_q    <= fin_flag;
			len_q    <= payload_len;
			handle_q <= payload_handle[HANDLE_BITS-1:0];
		end
		if (emit) begin
			kind_q           <= e_kind;
			ack_number_q     <= e_ack_number;
			ack_fin_q        <= e_ack_fin;
			deliver_seq_q    <= e_deliver_seq;
			deliver_len_q    <= e_deliver_len;
			deliver_handle_q <= e_deliver_handle;
			last_q           <= e_last;
		end
	end

	assign res_valid      = res_valid_q;
	assign kind           = kind_q;
	assign ack_number     = ack_number_q;
	assign ack_fin        = ack_fin_q;
	assign deliver_seq    = deliver_seq_q;
	assign deliver_len    = deliver_len_q;
	assign deliver_handle = deliver_handle_q;
	assign last_of_run    = last_q;

	`SRRR_ASSERT(a_done_sticky, done_q |=> done_q, "transfer done flag dropped")
	`SRRR_ASSERT(a_drain_run, in_drain |-> (run_q != '0), "drain with empty run")
	`SRRR_ASSERT(a_exp_change, !$stable(expected_q) |-> $past(exp_step_ok), "expected seq jumped")
	`SRRR_ASSERT(a_emit_free, emit |-> out_free, "result overwrote a pending transaction")
	`SRRR_ASSERT(a_done_quiet, $past(done_q) && state_q == S_DECIDE |-> !emit, "result after done")

endmodule
